>>> hw/rtl/cdbc_pkg.sv
// ----------------------------------------------------------------------------
// cdbc_pkg
// Shared types and codes of the cursor DIB to BGRA converter: item functions,
// pixel formats, register indexes and the controller states.
// ----------------------------------------------------------------------------
package cdbc_pkg;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        REG_BPP_MODE      = 2'd0,
        REG_PALETTE_COUNT = 2'd1,
        REG_FRAME_WIDTH   = 2'd2,
        REG_FRAME_HEIGHT  = 2'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_RESULT
    } t_state;

    localparam logic [2:0] BPP_1  = 3'd0;
    localparam logic [2:0] BPP_4  = 3'd1;
    localparam logic [2:0] BPP_8  = 3'd2;
    localparam logic [2:0] BPP_24 = 3'd3;
    localparam logic [2:0] BPP_32 = 3'd4;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    localparam int CFG_DATA_W = 9;

endpackage

>>> hw/rtl/cursor_dib_to_bgra_converter.sv
// ----------------------------------------------------------------------------
// cursor_dib_to_bgra_converter
// Decodes one cursor DIB frame into top-down BGRA pixels held in a pixel
// memory; a palette memory serves the 1, 4 and 8 bpp formats.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        sink       i_in_valid / o_in_stall    func, row, column, index, bytes
//  out       source     o_out_valid / i_out_stall  blue, green, red, alpha
//  cfg       sink       i_cfg_wr_en                index, wdata
//
//  Start, load and 24/32 bpp write words finish as they are taken.
//  Palette writes (1/4/8 bpp) go through a palette memory read, then the pixel write.
//  Reads go through a pixel memory read, then the output register.
//  A read holds the input until the output register can take its result;
//  other words are still taken while a result waits.
//  Reset sets control state and configuration only; both memories hold no reset value.
// ----------------------------------------------------------------------------
module cursor_dib_to_bgra_converter
    import cdbc_pkg::*;
#(
    parameter int MAX_WIDTH     = 64,
    parameter int MAX_HEIGHT    = 64,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_func,
    input  logic [5:0]            i_row,
    input  logic [5:0]            i_column,
    input  logic [7:0]            i_palette_index,
    input  logic [7:0]            i_byte_zero,
    input  logic [7:0]            i_byte_one,
    input  logic [7:0]            i_byte_two,
    input  logic [7:0]            i_byte_three,
    input  logic [7:0]            i_mask_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_blue,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_alpha
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int PW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [10:0] MAX_W = 11'(MAX_WIDTH);
    localparam logic [10:0] MAX_H = 11'(MAX_HEIGHT);
    localparam logic [8:0]  PAL_LIMIT = 9'(PALETTE_DEPTH);

    // configuration
    logic [2:0] r_bpp_mode;
    logic [8:0] r_palette_count;
    logic [6:0] r_frame_width;
    logic [6:0] r_frame_height;

    // control
    t_state r_state, n_state;
    logic   r_alpha_seen;
    logic   r_rd_miss;
    logic   r_wr_mask;
    logic   r_wr_hit;
    logic [AW-1:0] r_wr_addr;

    // memories
    logic [23:0] r_pal_mem [PALETTE_DEPTH];
    logic [23:0] r_pal_q;
    logic [32:0] r_store_mem [STORE_DEPTH];
    logic [32:0] r_store_q;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_blue, r_out_green, r_out_red, r_out_alpha;

    t_func      w_func;
    logic       w_accept;
    logic       w_out_free;
    logic       w_load_out;
    logic       w_lookup;
    logic [6:0] w_eff_w, w_eff_h, w_flip;
    logic       w_in_frame;
    logic [31:0] w_wr_full, w_rd_full;
    logic [AW-1:0] w_wr_addr, w_rd_addr;
    logic       w_wr_item, w_direct, w_pal_re, w_is32;
    logic [2:0] w_bit_sel;
    logic       w_mask;
    logic [7:0] w_idx;
    logic [8:0] w_full_count, w_count;
    logic       w_pal_hit;
    logic [23:0] w_direct_bgr, w_lookup_bgr;
    logic [7:0]  w_direct_alpha, w_lookup_alpha;
    logic        w_store_we;
    logic [AW-1:0] w_store_waddr;
    logic [32:0]   w_store_wdata;
    logic [7:0]  w_res_alpha;

    assign w_func = t_func'(i_func);

    // ---------------- frame geometry ----------------
    assign w_eff_w = ({4'b0, r_frame_width}  < MAX_W) ? r_frame_width  : MAX_W[6:0];
    assign w_eff_h = ({4'b0, r_frame_height} < MAX_H) ? r_frame_height : MAX_H[6:0];
    assign w_in_frame = ({1'b0, i_row} < w_eff_h) && ({1'b0, i_column} < w_eff_w);
    // flip the bottom-up DIB row to a top-down memory row
    assign w_flip    = w_eff_h - 7'd1 - {1'b0, i_row};
    assign w_wr_full = 32'(w_flip) * 32'(MAX_WIDTH) + 32'(i_column);
    assign w_rd_full = 32'(i_row) * 32'(MAX_WIDTH) + 32'(i_column);
    assign w_wr_addr = w_wr_full[AW-1:0];
    assign w_rd_addr = w_rd_full[AW-1:0];

    // ---------------- pixel decode ----------------
    assign w_is32    = (r_bpp_mode >= BPP_32);
    assign w_wr_item = w_accept && (w_func == FUNC_WRITE) && w_in_frame;
    assign w_direct  = w_wr_item && (r_bpp_mode >= BPP_24);
    assign w_pal_re  = w_wr_item && (r_bpp_mode < BPP_24);

    assign w_bit_sel = 3'd7 - i_column[2:0];
    assign w_mask    = i_mask_byte[w_bit_sel];

    always_comb begin
        case (r_bpp_mode)
            BPP_1: begin
                w_idx        = {7'b0, i_byte_zero[w_bit_sel]};
                w_full_count = 9'd2;
            end
            BPP_4: begin
                w_idx        = {4'b0, (i_column[0] ? i_byte_zero[3:0] : i_byte_zero[7:4])};
                w_full_count = 9'd16;
            end
            default: begin
                w_idx        = i_byte_zero;
                w_full_count = 9'd256;
            end
        endcase
    end

    assign w_count   = (r_palette_count != 9'd0) ? r_palette_count : w_full_count;
    assign w_pal_hit = ({1'b0, w_idx} < w_count) && ({1'b0, w_idx} < PAL_LIMIT);

    assign w_direct_bgr   = {i_byte_two, i_byte_one, i_byte_zero};
    assign w_direct_alpha = w_is32 ? i_byte_three :
                            ((w_mask && (w_direct_bgr == 24'd0)) ? ALPHA_CLEAR : ALPHA_OPAQUE);
    assign w_lookup_bgr   = r_wr_hit ? r_pal_q : 24'd0;
    assign w_lookup_alpha = (r_wr_mask && (w_lookup_bgr == 24'd0)) ? ALPHA_CLEAR : ALPHA_OPAQUE;

    assign w_store_we    = w_direct || w_lookup;
    assign w_store_waddr = w_lookup ? r_wr_addr : w_wr_addr;
    assign w_store_wdata = w_lookup ? {r_wr_mask, w_lookup_alpha, w_lookup_bgr}
                                    : {w_mask, w_direct_alpha, w_direct_bgr};

    // ---------------- controller ----------------
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_pal_re) begin
                    n_state = ST_LOOKUP;
                end else if (w_accept && (w_func == FUNC_READ)) begin
                    n_state = ST_RESULT;
                end
            end
            ST_LOOKUP: begin
                n_state = ST_IDLE;
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_lookup   = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_stall = 1'b0;
            ST_LOOKUP: w_lookup   = 1'b1;
            ST_RESULT: w_load_out = w_out_free;
            default:   o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_alpha_seen    <= 1'b0;
            r_out_valid     <= 1'b0;
            r_bpp_mode      <= BPP_32;
            r_palette_count <= 9'd0;
            r_frame_width   <= 7'd32;
            r_frame_height  <= 7'd32;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                unique case (t_reg_index'(i_cfg_index))
                    REG_BPP_MODE:      r_bpp_mode      <= i_cfg_wdata[2:0];
                    REG_PALETTE_COUNT: r_palette_count <= i_cfg_wdata[8:0];
                    REG_FRAME_WIDTH:   r_frame_width   <= i_cfg_wdata[6:0];
                    REG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (w_accept && (w_func == FUNC_START)) begin
                r_alpha_seen <= 1'b0;
            end else if (w_direct && w_is32 && (i_byte_three != 8'd0)) begin
                r_alpha_seen <= 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the write context across the palette read, and the read miss flag
    always_ff @(posedge i_clk) begin
        if (w_pal_re) begin
            r_wr_addr <= w_wr_addr;
            r_wr_mask <= w_mask;
            r_wr_hit  <= w_pal_hit;
        end
        if (w_accept && (w_func == FUNC_READ)) begin
            r_rd_miss <= !w_in_frame;
        end
    end

    // palette memory
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_func == FUNC_LOAD) && ({1'b0, i_palette_index} < PAL_LIMIT)) begin
            r_pal_mem[i_palette_index[PW-1:0]] <= {i_byte_two, i_byte_one, i_byte_zero};
        end
        if (w_pal_re) begin
            r_pal_q <= r_pal_mem[w_idx[PW-1:0]];
        end
    end

    // pixel memory
    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store_mem[w_store_waddr] <= w_store_wdata;
        end
        if (w_accept && (w_func == FUNC_READ) && w_in_frame) begin
            r_store_q <= r_store_mem[w_rd_addr];
        end
    end

    // fall back to the mask when no 32 bpp alpha of the frame was nonzero
    assign w_res_alpha = (w_is32 && !r_alpha_seen) ?
                         (r_store_q[32] ? ALPHA_CLEAR : ALPHA_OPAQUE) : r_store_q[31:24];

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            if (r_rd_miss) begin
                r_out_blue  <= 8'd0;
                r_out_green <= 8'd0;
                r_out_red   <= 8'd0;
                r_out_alpha <= 8'd0;
            end else begin
                r_out_blue  <= r_store_q[7:0];
                r_out_green <= r_store_q[15:8];
                r_out_red   <= r_store_q[23:16];
                r_out_alpha <= w_res_alpha;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_blue  = r_out_blue;
    assign o_out_green = r_out_green;
    assign o_out_red   = r_out_red;
    assign o_out_alpha = r_out_alpha;

endmodule

>>> hw/rtl/cdbc_checker.sv
// ----------------------------------------------------------------------------
// cdbc_checker
// Port-level checks of the cursor DIB to BGRA converter, bound to the top.
// ----------------------------------------------------------------------------
module cdbc_checker
    import cdbc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_func,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_blue,
    input logic [7:0] o_out_alpha
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    // a read word blocks the input while its pixel is fetched
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_func == FUNC_READ)) |=> o_in_stall)
        else $error("input taken during read fetch");

    // start and load words leave the input unstalled in the next cycle
    a_short_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && ((i_func == FUNC_START) || (i_func == FUNC_LOAD))) |=> !o_in_stall)
        else $error("input stalled after start or load word");

    // a read result loads the output register after the pixel fetch when the output has room
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_func == FUNC_READ)) ##1 (!o_out_valid || !i_out_stall)
        |=> o_out_valid)
        else $error("read result missing");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_out_blue) && $stable(o_out_alpha)))
        else $error("stalled result changed");

endmodule

bind cursor_dib_to_bgra_converter cdbc_checker u_cdbc_checker (.*);
